FILE: hw/rtl/wpm_pkg.sv
// Shared types and constants for the wildcard pattern matcher.
// No dependencies. Used by the cell, the closure network and the top level.
`timescale 1ns / 1ps
`default_nettype none

package wpm_pkg;

  // pattern capacity in bytes and number of match positions (one past the end)
  localparam int MAX_PATTERN = 64;
  localparam int NPOS        = MAX_PATTERN + 1;
  localparam int LEN_W       = $clog2(NPOS);

  // wildcard codes
  localparam logic [7:0] CH_ANY  = 8'd63;
  localparam logic [7:0] CH_STAR = 8'd42;

  // per-cell flags toward the position vector and the closure network
  typedef struct packed {
    logic stay;  // active star keeps its own position
    logic step;  // active literal or '?' matched, hand off to the neighbor
    logic prop;  // stored star inside the pattern, lets activity ripple on
  } cell_out_t;

endpackage

`default_nettype wire

FILE: hw/rtl/wildcard_pattern_match_top.sv
// Glob matcher ('?' and '*') built as a row of pattern cells.
// Depends on wpm_pkg, wpm_cell and wpm_closure.
//
// Usage:
//   Input channel (in_valid / in_stall) carries mode, char_value, has_char,
//   last. mode 0 loads a pattern byte; mode 1 streams a resource byte.
//   A pattern item after a closed pattern starts a new pattern; a pattern
//   item also drops any resource in progress without a result.
//   Output channel (out_valid / out_stall) carries matched and
//   pattern_overflow, one transfer per resource item with last set.
//   Throughput: one item per cycle while in_stall is low, pattern or
//   resource. Every cell updates its active bit in the same cycle; the
//   star closure is a 7-level prefix network, so no item waits on the
//   previous one. Result: registered, in the output register or, when
//   that is full and stalled, in the skid register.
//   Stall: a result that finds the output register full and stalled goes
//   to a one-entry skid register; in_stall is high only while that skid
//   entry is occupied, so input keeps flowing under one stalled result.
//   Reset: synchronous; empties both result registers, clears the stored
//   pattern length and flags. No clearing pass is needed.
`timescale 1ns / 1ps
`default_nettype none

module wildcard_pattern_match_top (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic       mode,
  input  logic [7:0] char_value,
  input  logic       has_char,
  input  logic       last,
  output logic       out_valid,
  input  logic       out_stall,
  output logic       matched,
  output logic       pattern_overflow
);
  import wpm_pkg::*;

  logic [LEN_W-1:0] pattern_length;
  logic             pattern_closed;
  logic             overflow_seen;
  logic             resource_busy;
  logic             all_star;
  logic [NPOS-1:0]  start_set;
  logic [NPOS-1:0]  active_set;

  logic             in_xfer;
  logic             pat_xfer;
  logic             res_xfer;
  logic             produce;
  logic [LEN_W-1:0] len_eff;
  logic             room;
  logic             store;
  logic [LEN_W-1:0] wr_pos;
  logic             char_star;

  logic [MAX_PATTERN-1:0] used;
  logic [MAX_PATTERN-1:0] wr_sel;
  logic [MAX_PATTERN-1:0] prop;
  cell_out_t              co [MAX_PATTERN];
  logic [NPOS-1:0]        cur_set;
  logic [NPOS-1:0]        adv_set;
  logic [NPOS-1:0]        closed_set;
  logic [NPOS-1:0]        new_set;
  logic                   res_matched;

  logic skid_valid;
  logic skid_matched;
  logic skid_overflow;

  // input transfer decode
  assign in_stall = skid_valid;
  assign in_xfer  = in_valid && !in_stall;
  assign pat_xfer = in_xfer && !mode;
  assign res_xfer = in_xfer && mode;
  assign produce  = res_xfer && last;

  // pattern write position; a closed pattern restarts from zero
  assign len_eff   = pattern_closed ? '0 : pattern_length;
  assign room      = (len_eff < LEN_W'(MAX_PATTERN));
  assign store     = pat_xfer && has_char && room;
  assign wr_pos    = len_eff + LEN_W'(1);
  assign char_star = (char_value == CH_STAR);

  // position set for the byte: closure of position zero at the start of a resource, else the held set
  assign cur_set = resource_busy ? active_set : start_set;

  // row of pattern cells
  for (genvar i = 0; i < MAX_PATTERN; i++) begin : g_cell
    assign used[i]   = (LEN_W'(i) < pattern_length);
    assign wr_sel[i] = store && (len_eff == LEN_W'(i));
    assign prop[i]   = co[i].prop;

    wpm_cell u_cell (
      .clk     (clk),
      .wr_en   (wr_sel[i]),
      .char_in (char_value),
      .used    (used[i]),
      .active  (cur_set[i]),
      .co      (co[i])
    );
  end

  // each position takes its own star hold and the left neighbor's step
  always_comb begin
    adv_set[0] = co[0].stay;
    for (int j = 1; j < MAX_PATTERN; j++) begin
      adv_set[j] = co[j].stay | co[j-1].step;
    end
    adv_set[MAX_PATTERN] = co[MAX_PATTERN-1].step;
  end

  wpm_closure u_closure (
    .gen    (adv_set),
    .prop   (prop),
    .closed (closed_set)
  );

  assign new_set     = has_char ? closed_set : cur_set;
  assign res_matched = !overflow_seen && new_set[pattern_length];

  // pattern bookkeeping and resource position set
  always_ff @(posedge clk) begin
    if (rst) begin
      pattern_length <= '0;
      pattern_closed <= 1'b0;
      overflow_seen  <= 1'b0;
      resource_busy  <= 1'b0;
      all_star       <= 1'b1;
      start_set      <= NPOS'(1);
    end else if (pat_xfer) begin
      pattern_length <= store ? wr_pos : len_eff;
      pattern_closed <= last;
      overflow_seen  <= (overflow_seen && !pattern_closed) || (has_char && !room);
      resource_busy  <= 1'b0;
      if (pattern_closed) begin
        all_star  <= store ? char_star : 1'b1;
        start_set <= NPOS'(1) | (store && char_star ? NPOS'(2) : '0);
      end else if (store) begin
        all_star <= all_star && char_star;
        for (int j = 1; j < NPOS; j++) begin
          if (wr_pos == LEN_W'(j)) begin
            start_set[j] <= all_star && char_star;
          end
        end
      end
    end else if (res_xfer) begin
      resource_busy <= !last;
    end
  end

  always_ff @(posedge clk) begin
    if (res_xfer) begin
      active_set <= new_set;
    end
  end

  // output register with one skid entry
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (!out_valid || !out_stall) begin
      if (skid_valid) begin
        out_valid  <= 1'b1;
        skid_valid <= 1'b0;
      end else begin
        out_valid <= produce;
      end
    end else if (produce) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!out_valid || !out_stall) begin
      if (skid_valid) begin
        matched          <= skid_matched;
        pattern_overflow <= skid_overflow;
      end else if (produce) begin
        matched          <= res_matched;
        pattern_overflow <= overflow_seen;
      end
    end else if (produce) begin
      skid_matched  <= res_matched;
      skid_overflow <= overflow_seen;
    end
  end

endmodule

`default_nettype wire

FILE: hw/rtl/wpm_cell.sv
// One pattern cell: holds one stored pattern byte and advances its position.
// Depends on wpm_pkg.
`timescale 1ns / 1ps
`default_nettype none

module wpm_cell (
  input  logic               clk,
  input  logic               wr_en,
  input  logic [7:0]         char_in,
  input  logic               used,
  input  logic               active,
  output wpm_pkg::cell_out_t co
);
  import wpm_pkg::*;

  logic [7:0] pattern_byte;
  logic       is_star;
  logic       hit;

  // pattern byte store, written once per pattern load
  always_ff @(posedge clk) begin
    if (wr_en) begin
      pattern_byte <= char_in;
    end
  end

  // compare against the incoming resource byte
  assign is_star = (pattern_byte == CH_STAR);
  assign hit     = (pattern_byte == CH_ANY) || (pattern_byte == char_in);

  assign co.stay = used && active && is_star;
  assign co.step = used && active && !is_star && hit;
  assign co.prop = used && is_star;

endmodule

`default_nettype wire

FILE: hw/rtl/wpm_closure.sv
// Star closure: a parallel prefix network that carries activity across runs
// of stored stars. Depends on wpm_pkg.
`timescale 1ns / 1ps
`default_nettype none

module wpm_closure (
  input  logic [wpm_pkg::NPOS-1:0]        gen,
  input  logic [wpm_pkg::MAX_PATTERN-1:0] prop,
  output logic [wpm_pkg::NPOS-1:0]        closed
);
  import wpm_pkg::*;

  localparam int LVLS = $clog2(NPOS);

  logic [NPOS-1:0] g_lv [LVLS+1];
  logic [NPOS-1:0] p_lv [LVLS+1];

  // position j inherits from j-1 when cell j-1 holds a star
  always_comb begin
    g_lv[0] = gen;
    p_lv[0] = {prop, 1'b0};
    for (int l = 0; l < LVLS; l++) begin
      for (int j = 0; j < NPOS; j++) begin
        if (j >= (1 << l)) begin
          g_lv[l+1][j] = g_lv[l][j] | (p_lv[l][j] & g_lv[l][j - (1 << l)]);
          p_lv[l+1][j] = p_lv[l][j] & p_lv[l][j - (1 << l)];
        end else begin
          g_lv[l+1][j] = g_lv[l][j];
          p_lv[l+1][j] = p_lv[l][j];
        end
      end
    end
  end

  assign closed = g_lv[LVLS];

endmodule

`default_nettype wire

FILE: hw/rtl/wpm_checker.sv
// Port-level checks for the wildcard pattern matcher, bound to the top level.
// Depends on wildcard_pattern_match_top.
`timescale 1ns / 1ps
`default_nettype none

module wpm_checker (
  input logic       clk,
  input logic       rst,
  input logic       in_valid,
  input logic       in_stall,
  input logic       mode,
  input logic [7:0] char_value,
  input logic       has_char,
  input logic       last,
  input logic       out_valid,
  input logic       out_stall,
  input logic       matched,
  input logic       pattern_overflow
);

  // a stalled result stays offered
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid)
    else $error("result dropped while stalled");

  // an overflowed pattern never reports a match
  a_ovf_nomatch: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(matched && pattern_overflow))
    else $error("match reported with pattern overflow");

  // the final resource transfer is always followed by a valid output next cycle
  a_res_result: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall && mode && last |=> out_valid)
    else $error("missing result after final resource byte");

  // a pattern transfer while no result is offered never creates one
  a_pat_silent: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall && !mode && !out_valid |=> !out_valid)
    else $error("result appeared after a pattern transfer");

endmodule

bind wildcard_pattern_match_top wpm_checker u_wpm_checker (.*);

`default_nettype wire
